[src/rwsd_pkg.sv]
// Shared types and constants of the random work-stealing dispatch unit.
`timescale 1ns / 1ps

package rwsd_pkg;

    // Field and state widths
    localparam int REMOTE_W   = 15;
    localparam int VICTIM_W   = 4;
    localparam int COUNT_W    = 4;
    localparam int RND_W      = 32;
    localparam int WC_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default for the top-level pool limit
    localparam int MAX_REMOTE_POOLS_DEF = 15;

    // Work counter masks
    localparam logic [WC_W-1:0] MASK_LOCAL  = WC_W'(16 - 1);
    localparam logic [WC_W-1:0] MASK_REMOTE = WC_W'(256 - 1);
    localparam logic [WC_W-1:0] MASK_EVENT  = WC_W'(8192 - 1);

    // xorshift32 shift amounts and reset seed
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;
    localparam logic [RND_W-1:0] SEED_RESET = 32'd2463534242;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_POOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_START        = 2'd1;

    // Control into the serial remainder unit
    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_ctrl_t;

    // Status out of the serial remainder unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COUNT_W-1:0] rem;
    } mod_stat_t;

endpackage

[src/rwsd_rng.sv]
// xorshift32 random state register with seed load and single-step advance.
`timescale 1ns / 1ps

module rwsd_rng (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_en,
    input  logic [rwsd_pkg::RND_W-1:0] load_val,
    input  logic                       step,
    output logic [rwsd_pkg::RND_W-1:0] rnd_next
);

    logic [rwsd_pkg::RND_W-1:0] state_reg;
    logic [rwsd_pkg::RND_W-1:0] state_next;
    logic [rwsd_pkg::RND_W-1:0] s1;
    logic [rwsd_pkg::RND_W-1:0] s2;

    // Form the next xorshift value
    always_comb begin
        s1       = state_reg ^ (state_reg << rwsd_pkg::SHIFT_A);
        s2       = s1 ^ (s1 >> rwsd_pkg::SHIFT_B);
        rnd_next = s2 ^ (s2 << rwsd_pkg::SHIFT_C);
    end

    // Load the seed or advance on request
    always_comb begin
        state_next = state_reg;
        priority if (load_en) begin
            state_next = load_val;
        end else if (step) begin
            state_next = rnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rwsd_pkg::SEED_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/rwsd_mod.sv]
// Bit-serial remainder of a 32-bit value by a small nonzero pool count.
`timescale 1ns / 1ps

module rwsd_mod (
    input  logic                aclk,
    input  logic                aresetn,
    input  rwsd_pkg::mod_ctrl_t ctrl,
    output rwsd_pkg::mod_stat_t stat
);

    localparam int CNT_W = $clog2(rwsd_pkg::RND_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(rwsd_pkg::RND_W - 1);

    logic [rwsd_pkg::RND_W-1:0]   shift_reg;
    logic [rwsd_pkg::COUNT_W-1:0] rem_reg;
    logic [rwsd_pkg::COUNT_W-1:0] div_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [rwsd_pkg::COUNT_W:0]   trial;
    logic [rwsd_pkg::COUNT_W:0]   diff;
    logic [rwsd_pkg::COUNT_W-1:0] rem_next;

    // Bring in one dividend bit and subtract the divisor when it fits
    always_comb begin
        trial = {rem_reg, shift_reg[rwsd_pkg::RND_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = diff[rwsd_pkg::COUNT_W-1:0];
        end else begin
            rem_next = trial[rwsd_pkg::COUNT_W-1:0];
        end
    end

    // Control: run one bit per cycle from start to the last bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out and the remainder along
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            shift_reg <= ctrl.dividend;
            div_reg   <= ctrl.divisor;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

[src/random_work_stealing_dispatch_unit.sv]
// Top level of the random work-stealing dispatch unit: round control and result register.
// Each accepted item is one scheduler round and yields one result item. A round
// with no steal attempt, or a round after the block has halted, passes from the
// idle state to the finish state, which loads the result register; the next item
// is accepted once the block is back in the idle state. A round that tries a steal
// waits in the remainder state in between: the victim is the next xorshift32 value
// modulo the pool count, worked out one dividend bit per cycle in the serial
// remainder unit, then collected as the round moves on to the finish state, which
// loads the result register. The input is taken again once the round has been
// written to the result register, which can hold a finished result while the next
// round is accepted; a result stalled at the output keeps the round waiting and the
// input closed. Writing seed_start also reloads the random state.
`timescale 1ns / 1ps

module random_work_stealing_dispatch_unit #(
    parameter int MAX_REMOTE_POOLS = rwsd_pkg::MAX_REMOTE_POOLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [rwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // round input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_private_ready,
    input  logic                            s_shared_ready,
    input  logic [rwsd_pkg::REMOTE_W-1:0]   s_remote_ready,
    input  logic                            s_stop_request,
    // round result
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_served_private,
    output logic                            m_polled_shared,
    output logic                            m_served_shared,
    output logic                            m_steal_tried,
    output logic [rwsd_pkg::VICTIM_W-1:0]   m_victim,
    output logic                            m_stole,
    output logic                            m_events_checked,
    output logic                            m_halted
);

    localparam logic [rwsd_pkg::COUNT_W-1:0] COUNT_CAP =
        (MAX_REMOTE_POOLS >= 15) ? 4'd15 : rwsd_pkg::COUNT_W'(MAX_REMOTE_POOLS);
    localparam logic [rwsd_pkg::VICTIM_W-1:0] VICTIM_LIMIT =
        rwsd_pkg::VICTIM_W'(rwsd_pkg::REMOTE_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    logic [rwsd_pkg::COUNT_W-1:0]  pool_count_reg;
    logic [rwsd_pkg::WC_W-1:0]     wc_reg;
    logic                          stopped_reg;

    // round working registers
    logic                          halt_rnd_reg;
    logic                          sp_reg;
    logic                          ps_reg;
    logic                          ss_reg;
    logic                          st_reg;
    logic                          stop_req_reg;
    logic [rwsd_pkg::REMOTE_W-1:0] remote_reg;
    logic [rwsd_pkg::WC_W-1:0]     wc_mid_reg;
    logic [rwsd_pkg::VICTIM_W-1:0] victim_reg;

    // result register
    logic                          m_valid_reg;
    logic                          o_sp_reg;
    logic                          o_ps_reg;
    logic                          o_ss_reg;
    logic                          o_st_reg;
    logic [rwsd_pkg::VICTIM_W-1:0] o_victim_reg;
    logic                          o_stole_reg;
    logic                          o_ev_reg;
    logic                          o_halt_reg;

    logic                          accept;
    logic                          out_free;
    logic [rwsd_pkg::COUNT_W-1:0]  count_sat;
    logic [rwsd_pkg::WC_W-1:0]     wc_a;
    logic [rwsd_pkg::WC_W-1:0]     wc_b;
    logic                          polled;
    logic                          served_sh;
    logic                          steal_go;
    logic                          stole_now;
    logic [rwsd_pkg::WC_W-1:0]     wc_end;
    logic                          events_now;
    logic                          rng_load;
    logic [rwsd_pkg::RND_W-1:0]    rnd_next;
    rwsd_pkg::mod_ctrl_t           mod_ctrl;
    rwsd_pkg::mod_stat_t           mod_stat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Saturate the pool count at the configured limit
    assign count_sat = (pool_count_reg > COUNT_CAP) ? COUNT_CAP : pool_count_reg;

    // Serve the private pool, then decide on the shared poll and the steal
    always_comb begin
        wc_a      = wc_reg + rwsd_pkg::WC_W'(s_private_ready);
        polled    = !s_private_ready || ((wc_a & rwsd_pkg::MASK_LOCAL) == '0);
        served_sh = polled && s_shared_ready;
        wc_b      = wc_a + rwsd_pkg::WC_W'(served_sh);
        steal_go  = (!(s_private_ready || served_sh) ||
                     ((wc_b & rwsd_pkg::MASK_REMOTE) == '0)) && (count_sat != '0);
    end

    // Close the round: steal hit, final count step and event check
    always_comb begin
        stole_now  = st_reg && (victim_reg < VICTIM_LIMIT) && remote_reg[victim_reg];
        wc_end     = (wc_mid_reg + rwsd_pkg::WC_W'(stole_now) + 1'b1) & rwsd_pkg::MASK_EVENT;
        events_now = (wc_end == '0);
    end

    assign rng_load          = cfg_wr_en && (cfg_index == rwsd_pkg::CFG_SEED_START);
    assign mod_ctrl.start    = accept && !stopped_reg && steal_go;
    assign mod_ctrl.dividend = rnd_next;
    assign mod_ctrl.divisor  = count_sat;

    rwsd_rng u_rng (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (rng_load),
        .load_val (cfg_wdata[rwsd_pkg::RND_W-1:0]),
        .step     (mod_ctrl.start),
        .rnd_next (rnd_next)
    );

    rwsd_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mod_ctrl),
        .stat    (mod_stat)
    );

    // Hold the pool count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_count_reg <= '0;
        end else if (cfg_wr_en && (cfg_index == rwsd_pkg::CFG_REMOTE_POOL_COUNT)) begin
            pool_count_reg <= cfg_wdata[rwsd_pkg::COUNT_W-1:0];
        end
    end

    // Sequence the round and drive the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wc_reg      <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (mod_ctrl.start) begin
                            state_reg <= ST_MOD;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_MOD: begin
                    if (mod_stat.done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (!halt_rnd_reg) begin
                            wc_reg <= wc_end;
                            if (events_now && stop_req_reg) begin
                                stopped_reg <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the round's inputs and first decisions
    always_ff @(posedge aclk) begin
        if (accept) begin
            halt_rnd_reg <= stopped_reg;
            sp_reg       <= s_private_ready;
            ps_reg       <= polled;
            ss_reg       <= served_sh;
            st_reg       <= steal_go;
            stop_req_reg <= s_stop_request;
            remote_reg   <= s_remote_ready;
            wc_mid_reg   <= wc_b;
            victim_reg   <= '0;
        end else if (mod_stat.done) begin
            victim_reg <= mod_stat.rem;
        end
    end

    // Load the result fields; a halted round reports only halted
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FINISH) && out_free) begin
            o_sp_reg     <= !halt_rnd_reg && sp_reg;
            o_ps_reg     <= !halt_rnd_reg && ps_reg;
            o_ss_reg     <= !halt_rnd_reg && ss_reg;
            o_st_reg     <= !halt_rnd_reg && st_reg;
            o_victim_reg <= (!halt_rnd_reg && st_reg) ? victim_reg : '0;
            o_stole_reg  <= !halt_rnd_reg && stole_now;
            o_ev_reg     <= !halt_rnd_reg && events_now;
            o_halt_reg   <= halt_rnd_reg || (events_now && stop_req_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_served_private = o_sp_reg;
    assign m_polled_shared  = o_ps_reg;
    assign m_served_shared  = o_ss_reg;
    assign m_steal_tried    = o_st_reg;
    assign m_victim         = o_victim_reg;
    assign m_stole          = o_stole_reg;
    assign m_events_checked = o_ev_reg;
    assign m_halted         = o_halt_reg;

    // Once halted, the block stays halted until reset
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    // The remainder unit runs only while the round waits for it
    a_mod_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.busy |-> (state_reg == ST_MOD))
        else $error("remainder unit busy outside its wait state");

    // Without a steal attempt there is no victim and no theft
    a_no_steal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_steal_tried) |-> ((m_victim == '0) && !m_stole))
        else $error("victim or stole reported without a steal attempt");

    // A steal attempt reports a victim below the pool count
    a_victim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_steal_tried) |-> (m_victim < count_sat))
        else $error("victim index not below the pool count");

endmodule

[tb/tb.sv]
// Self-checking testbench for the random work-stealing dispatch unit.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_POOLS     = rwsd_pkg::MAX_REMOTE_POOLS_DEF;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IDLE_SETTLE   = 4;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ROUNDS  = 196;
    localparam int PHASE_COUNT   = 6;

    // register indexes that map to no register
    localparam logic [rwsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [rwsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef logic [rwsd_pkg::VICTIM_W-1:0] field_t;

    typedef struct packed {
        logic                          private_ready;
        logic                          shared_ready;
        logic [rwsd_pkg::REMOTE_W-1:0] remote_ready;
        logic                          stop_request;
    } round_in_t;

    typedef struct packed {
        logic                          served_private;
        logic                          polled_shared;
        logic                          served_shared;
        logic                          steal_tried;
        logic [rwsd_pkg::VICTIM_W-1:0] victim;
        logic                          stole;
        logic                          events_checked;
        logic                          halted;
    } round_out_t;

    typedef struct packed {
        logic [rwsd_pkg::WC_W-1:0]  work_ctr;
        logic [rwsd_pkg::RND_W-1:0] rnd;
        logic                       stopped;
    } sched_state_t;

    typedef enum logic {ROW_ROUND, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [rwsd_pkg::CFG_IDX_W-1:0]  idx;
        logic [rwsd_pkg::CFG_DATA_W-1:0] data;
        round_in_t                       item;
        bit                              typed;
        round_out_t                      want;
    } dir_row_t;

    logic                            aclk             = 1'b0;
    logic                            aresetn          = 1'b0;
    logic                            cfg_wr_en        = 1'b0;
    logic [rwsd_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [rwsd_pkg::CFG_DATA_W-1:0] cfg_wdata        = '0;
    logic                            s_valid          = 1'b0;
    logic                            s_ready;
    logic                            s_private_ready  = 1'b0;
    logic                            s_shared_ready   = 1'b0;
    logic [rwsd_pkg::REMOTE_W-1:0]   s_remote_ready   = '0;
    logic                            s_stop_request   = 1'b0;
    logic                            m_valid;
    logic                            m_ready          = 1'b0;
    logic                            m_served_private;
    logic                            m_polled_shared;
    logic                            m_served_shared;
    logic                            m_steal_tried;
    logic [rwsd_pkg::VICTIM_W-1:0]   m_victim;
    logic                            m_stole;
    logic                            m_events_checked;
    logic                            m_halted;

    // scheduler mirror and expected rounds
    sched_state_t                    sched;
    logic [rwsd_pkg::COUNT_W-1:0]    pool_count_mdl;
    round_out_t                      pending_rounds[$];
    dir_row_t                        dir_table[$];

    int  err_count    = 0;
    bit  idle_en      = 1'b1;
    bit  hold_req     = 1'b0;

    random_work_stealing_dispatch_unit DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // One scheduler round: private pool, then shared poll, then a random steal.
    function automatic round_out_t dispatch_round(input round_in_t it, input sched_state_t cur,
                                                  input logic [rwsd_pkg::COUNT_W-1:0] pools,
                                                  output sched_state_t nxt);
        round_out_t                 o;
        int unsigned                served;
        int unsigned                cnt;
        int unsigned                vic;
        logic [rwsd_pkg::RND_W-1:0] r;
        o      = '0;
        nxt    = cur;
        served = 0;
        if (cur.stopped) begin
            o.halted = 1'b1;
            return o;
        end
        if (it.private_ready) begin
            o.served_private = 1'b1;
            served++;
            nxt.work_ctr = nxt.work_ctr + 1'b1;
        end
        if (served == 0 || (nxt.work_ctr & rwsd_pkg::MASK_LOCAL) == '0) begin
            o.polled_shared = 1'b1;
            if (it.shared_ready) begin
                o.served_shared = 1'b1;
                served++;
                nxt.work_ctr = nxt.work_ctr + 1'b1;
            end
        end
        if (served == 0 || (nxt.work_ctr & rwsd_pkg::MASK_REMOTE) == '0) begin
            cnt = (pools > MAX_POOLS) ? MAX_POOLS : pools;
            if (cnt > 0) begin
                r = nxt.rnd;
                r = r ^ (r << rwsd_pkg::SHIFT_A);
                r = r ^ (r >> rwsd_pkg::SHIFT_B);
                r = r ^ (r << rwsd_pkg::SHIFT_C);
                nxt.rnd       = r;
                o.steal_tried = 1'b1;
                vic           = r % cnt;
                o.victim      = vic[rwsd_pkg::VICTIM_W-1:0];
                // a victim past the ready field reads as empty
                if (vic < rwsd_pkg::REMOTE_W && it.remote_ready[vic]) begin
                    o.stole = 1'b1;
                    nxt.work_ctr = nxt.work_ctr + 1'b1;
                end
            end
        end
        nxt.work_ctr = nxt.work_ctr + 1'b1;
        if (nxt.work_ctr == '0) begin
            o.events_checked = 1'b1;
            if (it.stop_request)
                nxt.stopped = 1'b1;
        end
        o.halted = nxt.stopped;
        return o;
    endfunction

    function automatic round_out_t outcome(input logic sp, input logic ps, input logic ss,
                                           input logic st, input field_t vic,
                                           input logic sl, input logic ev, input logic h);
        outcome = '{sp, ps, ss, st, vic, sl, ev, h};
    endfunction

    function automatic round_in_t random_round();
        round_in_t it;
        it.private_ready = 1'($urandom_range(0, 1));
        it.shared_ready  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       it.remote_ready = '0;
            1:       it.remote_ready = '1;
            2:       it.remote_ready = rwsd_pkg::REMOTE_W'(1) <<
                                       $urandom_range(0, rwsd_pkg::REMOTE_W - 1);
            default: it.remote_ready = rwsd_pkg::REMOTE_W'($urandom);
        endcase
        it.stop_request = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    function automatic dir_row_t blank_row(input row_kind_t kind);
        dir_row_t row;
        row.kind  = kind;
        row.idx   = '0;
        row.data  = '0;
        row.item  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    task automatic add_round(input logic p, input logic s,
                             input logic [rwsd_pkg::REMOTE_W-1:0] r, input logic st);
        dir_row_t row;
        row       = blank_row(ROW_ROUND);
        row.item  = '{p, s, r, st};
        dir_table.push_back(row);
    endtask

    task automatic add_checked_round(input logic p, input logic s,
                                     input logic [rwsd_pkg::REMOTE_W-1:0] r, input logic st,
                                     input round_out_t want);
        dir_row_t row;
        row       = blank_row(ROW_ROUND);
        row.item  = '{p, s, r, st};
        row.typed = 1'b1;
        row.want  = want;
        dir_table.push_back(row);
    endtask

    task automatic add_write(input logic [rwsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rwsd_pkg::CFG_DATA_W-1:0] d);
        dir_row_t row;
        row      = blank_row(ROW_WRITE);
        row.idx  = idx;
        row.data = d;
        dir_table.push_back(row);
    endtask

    // Write a register once every round has come back.
    task automatic write_reg(input logic [rwsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rwsd_pkg::CFG_DATA_W-1:0] d);
        s_valid <= 1'b0;
        while (pending_rounds.size() != 0)
            @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        if (idx == rwsd_pkg::CFG_REMOTE_POOL_COUNT) begin
            pool_count_mdl = d[rwsd_pkg::COUNT_W-1:0];
        end else if (idx == rwsd_pkg::CFG_SEED_START) begin
            sched.rnd = d;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Predict one round, queue its result and hand it over.
    task automatic offer_round(input round_in_t it, input bit typed, input round_out_t want);
        round_out_t   got;
        sched_state_t nxt;
        got   = dispatch_round(it, sched, pool_count_mdl, nxt);
        sched = nxt;
        pending_rounds.push_back(typed ? want : got);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_private_ready <= it.private_ready;
        s_shared_ready  <= it.shared_ready;
        s_remote_ready  <= it.remote_ready;
        s_stop_request  <= it.stop_request;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic check_field(input string name, input field_t want, input field_t got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_round();
        round_out_t want;
        if (pending_rounds.size() == 0) begin
            $error("result item with no round pending");
            err_count++;
            return;
        end
        want = pending_rounds.pop_front();
        check_field("served_private", field_t'(want.served_private), field_t'(m_served_private));
        check_field("polled_shared", field_t'(want.polled_shared), field_t'(m_polled_shared));
        check_field("served_shared", field_t'(want.served_shared), field_t'(m_served_shared));
        check_field("steal_tried", field_t'(want.steal_tried), field_t'(m_steal_tried));
        check_field("victim", want.victim, m_victim);
        check_field("stole", field_t'(want.stole), field_t'(m_stole));
        check_field("events_checked", field_t'(want.events_checked), field_t'(m_events_checked));
        check_field("halted", field_t'(want.halted), field_t'(m_halted));
    endtask

    // Directed rounds: reset config, masking of wide writes, zero seed, one pool, unused indexes.
    task automatic build_dir_table();
        add_checked_round(1'b0, 1'b0, 15'h0000, 1'b0,
                          outcome(1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_checked_round(1'b1, 1'b1, 15'h7FFF, 1'b1,
                          outcome(1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_checked_round(1'b0, 1'b1, 15'h7FFF, 1'b1,
                          outcome(1'b0, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_checked_round(1'b1, 1'b0, 15'h0000, 1'b0,
                          outcome(1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_write(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'hFFFF_FFFF);
        add_round(1'b0, 1'b0, 15'h7FFF, 1'b0);
        add_round(1'b0, 1'b0, 15'h0000, 1'b1);
        add_round(1'b0, 1'b0, 15'h5555, 1'b0);
        add_round(1'b0, 1'b1, 15'h2AAA, 1'b0);
        add_round(1'b1, 1'b0, 15'h4000, 1'b0);
        // a zero seed never moves, so the victim stays 0
        add_write(rwsd_pkg::CFG_SEED_START, 32'h0000_0000);
        add_checked_round(1'b0, 1'b0, 15'h0001, 1'b0,
                          outcome(1'b0, 1'b1, 1'b0, 1'b1, '0, 1'b1, 1'b0, 1'b0));
        add_checked_round(1'b0, 1'b0, 15'h7FFE, 1'b1,
                          outcome(1'b0, 1'b1, 1'b0, 1'b1, '0, 1'b0, 1'b0, 1'b0));
        // one pool: every steal goes to pool 0
        add_write(rwsd_pkg::CFG_SEED_START, 32'hFFFF_FFFF);
        add_write(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'h0000_0001);
        add_checked_round(1'b0, 1'b0, 15'h0001, 1'b0,
                          outcome(1'b0, 1'b1, 1'b0, 1'b1, '0, 1'b1, 1'b0, 1'b0));
        add_checked_round(1'b0, 1'b0, 15'h0000, 1'b0,
                          outcome(1'b0, 1'b1, 1'b0, 1'b1, '0, 1'b0, 1'b0, 1'b0));
        // writes to unused indexes change nothing
        add_write(CFG_SPARE_2, 32'h0000_0000);
        add_write(CFG_SPARE_3, 32'hFFFF_FFFF);
        add_write(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'h0000_0012);
        add_round(1'b0, 1'b0, 15'h7FFF, 1'b0);
        add_round(1'b0, 1'b0, 15'h4001, 1'b0);
        add_write(rwsd_pkg::CFG_SEED_START, 32'h0000_0001);
        add_write(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'h0000_000E);
        add_round(1'b0, 1'b0, 15'h7FFF, 1'b0);
        add_round(1'b0, 1'b0, 15'h0001, 1'b0);
        add_round(1'b1, 1'b1, 15'h7FFF, 1'b1);
        add_write(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'h0000_000F);
        add_write(rwsd_pkg::CFG_SEED_START, 32'h8000_0000);
        add_round(1'b0, 1'b0, 15'h4000, 1'b0);
        add_round(1'b0, 1'b0, 15'h7FFF, 1'b0);
        add_round(1'b0, 1'b1, 15'h0000, 1'b0);
        add_round(1'b0, 1'b0, 15'h2AAA, 1'b0);
    endtask

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check every item, stall in bursts, and hold off once for a long stretch.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_taken;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                check_round();
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int ph;
        sched          = '{work_ctr: '0, rnd: rwsd_pkg::SEED_RESET, stopped: 1'b0};
        pool_count_mdl = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        build_dir_table();
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_WRITE)
                write_reg(dir_table[i].idx, dir_table[i].data);
            else
                offer_round(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
        end

        // random phases, each under its own pool count and seed
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       write_reg(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'd15);
                1:       write_reg(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'd1);
                2:       write_reg(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'd0);
                5:       write_reg(rwsd_pkg::CFG_REMOTE_POOL_COUNT, 32'd15);
                default: write_reg(rwsd_pkg::CFG_REMOTE_POOL_COUNT, $urandom_range(2, 14));
            endcase
            case (ph)
                1:       write_reg(rwsd_pkg::CFG_SEED_START, 32'hFFFF_FFFF);
                4:       write_reg(rwsd_pkg::CFG_SEED_START, 32'h0000_0001);
                default: write_reg(rwsd_pkg::CFG_SEED_START, $urandom_range(1, 32'hFFFF_FFFF));
            endcase
            // no idling in the last two phases
            idle_en = (ph < PHASE_COUNT - 2);
            if (ph == 3)
                hold_req = 1'b1;
            repeat (PHASE_ROUNDS)
                offer_round(random_round(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_rounds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
